### rtl/kli_pkg.sv
// Package: shared constants, types and codes for the keyframe interpolator.
`timescale 1ns / 1ps
`default_nettype none
package kli_pkg;

   localparam int MAX_KEYS  = 256;
   localparam int KEY_AW    = $clog2(MAX_KEYS);
   localparam int CNT_W     = 9;
   localparam int VAL_W     = 32;
   localparam int FRAME_W   = 16;
   localparam int RAW_W     = 16;
   localparam int FRAC_W    = 8;
   localparam int QT_W      = FRAME_W + FRAC_W;
   localparam int DIFF_W    = VAL_W + 1;
   localparam int SPAN_W    = QT_W + 1;
   localparam int PROD_W    = DIFF_W + SPAN_W;
   localparam int DEN_W     = QT_W;
   localparam int DIV_BITS  = 2;
   localparam int DIV_STEPS = (PROD_W + DIV_BITS - 1) / DIV_BITS;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam int SUM_W     = PROD_W + 2;
   localparam int CSR_AW    = 2;
   localparam int CSR_DW    = 32;

   localparam logic [RAW_W-1:0] RAW_FULL_SCALE = 16'hFFFF;

   localparam logic [CSR_AW-1:0] CSR_MIN_VALUE = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_MAX_VALUE = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_KEY_COUNT = 2'd2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SFIRST,
      ST_SWALK,
      ST_MUL,
      ST_DIVINIT,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic rd_first;
      logic walk;
      logic mul;
      logic div_init;
      logic div_step;
      logic mem_write;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_query;
      logic hit;
      logic skip;
   } ctrl_status_type;

   typedef struct packed {
      logic [FRAME_W-1:0]      frame;
      logic signed [VAL_W-1:0] value;
   } key_entry_type;

endpackage
`default_nettype wire

### rtl/kli_if.sv
// Interfaces: request and response channels of the keyframe interpolator.
`timescale 1ns / 1ps
`default_nettype none
interface kli_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [7:0]  key_slot;
   logic [15:0] key_frame;
   logic [15:0] key_raw;
   logic [23:0] query_time;

   modport source (output valid, cmd, key_slot, key_frame, key_raw, query_time,
                   input ready);
   modport sink   (input valid, cmd, key_slot, key_frame, key_raw, query_time,
                   output ready);
endinterface

interface kli_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample_value;
   logic               held_last;

   modport source (output valid, sample_value, held_last, input ready);
   modport sink   (input valid, sample_value, held_last, output ready);
endinterface
`default_nettype wire

### rtl/kli_ctrl.sv
// Controller: sequences key search, multiply, divide, table write and result delivery.
`timescale 1ns / 1ps
`default_nettype none
module kli_ctrl
   import kli_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = '0;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.is_query ? ST_SFIRST : ST_MUL;
            end
         end
         ST_SFIRST: begin
            cmd.rd_first = 1'b1;
            state_in     = ST_SWALK;
         end
         ST_SWALK: begin
            cmd.walk = 1'b1;
            if (status.hit) begin
               state_in = status.skip ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIVINIT;
         end
         ST_DIVINIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!status.is_query) begin
               cmd.mem_write = 1'b1;
               state_in      = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV) |-> (step_ff == '0))
      else $error("divide step counter active outside divide");
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && step_ff == STEP_W'(DIV_STEPS - 1)) |=> (state_ff == ST_DONE))
      else $error("divide did not end in done");
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside done");

endmodule
`default_nettype wire

### rtl/kli_datapath.sv
// Datapath: key table, search walk, shared multiplier and radix-4 divider.
`timescale 1ns / 1ps
`default_nettype none
module kli_datapath
   import kli_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [CSR_AW-1:0]   csr_index,
   input  wire logic [CSR_DW-1:0]   csr_wdata,
   input  wire logic                in_cmd,
   input  wire logic [KEY_AW-1:0]   in_slot,
   input  wire logic [FRAME_W-1:0]  in_frame,
   input  wire logic [RAW_W-1:0]    in_raw,
   input  wire logic [QT_W-1:0]     in_time,
   input  wire ctrl_cmd_type        cmd,
   output ctrl_status_type          status,
   output logic signed [VAL_W-1:0]  out_value,
   output logic                     out_held
);

   // configuration
   logic signed [VAL_W-1:0] min_ff, max_ff;
   logic [CNT_W-1:0]        cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= VAL_W'(65536);
         cnt_ff <= CNT_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_VALUE: min_ff <= csr_wdata;
            CSR_MAX_VALUE: max_ff <= csr_wdata;
            CSR_KEY_COUNT: cnt_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // captured item
   logic                cmd_ff;
   logic [KEY_AW-1:0]   slot_ff;
   logic [FRAME_W-1:0]  frame_ff;
   logic [RAW_W-1:0]    raw_ff;
   logic [QT_W-1:0]     qt_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= in_cmd;
         slot_ff  <= in_slot;
         frame_ff <= in_frame;
         raw_ff   <= in_raw;
         qt_ff    <= in_time;
      end
   end

   // key table
   key_entry_type      mem [MAX_KEYS];
   key_entry_type      rdata_ff;
   logic [KEY_AW-1:0]  rd_addr;
   logic [KEY_AW-1:0]  j_ff;
   logic [KEY_AW-1:0]  last_idx;
   logic [CNT_W-1:0]   cnt_m1;
   key_entry_type      prev_ff, cur_ff;
   logic               held_ff, flat_ff;
   logic signed [VAL_W-1:0] result;

   assign cnt_m1   = cnt_ff - 1'b1;
   assign last_idx = (cnt_ff == '0) ? '0 :
                     (cnt_ff > CNT_W'(MAX_KEYS)) ? KEY_AW'(MAX_KEYS - 1) :
                     cnt_m1[KEY_AW-1:0];
   assign rd_addr  = cmd.rd_first ? last_idx : j_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         mem[slot_ff] <= '{frame: frame_ff, value: result};
      end
      rdata_ff <= mem[rd_addr];
   end

   logic held_now, flat_now, hit_now;
   assign hit_now  = ({rdata_ff.frame, FRAC_W'(0)} <= qt_ff) || (j_ff == '0);
   assign held_now = (j_ff == last_idx);
   assign flat_now = (prev_ff.frame == rdata_ff.frame);

   assign status.is_query = cmd.capture ? (in_cmd == CMD_QUERY) : (cmd_ff == CMD_QUERY);
   assign status.hit      = hit_now;
   assign status.skip     = held_now || flat_now;

   always_ff @(posedge clock) begin
      if (cmd.rd_first) begin
         j_ff <= last_idx;
      end else if (cmd.walk) begin
         if (hit_now) begin
            cur_ff  <= rdata_ff;
            held_ff <= held_now;
            flat_ff <= !held_now && flat_now;
         end else begin
            prev_ff <= rdata_ff;
            j_ff    <= j_ff - 1'b1;
         end
      end else if (cmd.capture) begin
         held_ff <= 1'b0;
         flat_ff <= 1'b0;
      end
   end

   // multiply: (v2 - v1) * (t - t1) or (max - min) * raw
   logic signed [DIFF_W-1:0] mul_a;
   logic signed [SPAN_W-1:0] mul_b, den;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SPAN_W-1:0] den_ff;

   always_comb begin
      if (cmd_ff == CMD_QUERY) begin
         mul_a = DIFF_W'(prev_ff.value) - DIFF_W'(cur_ff.value);
         mul_b = $signed({1'b0, qt_ff}) - $signed({1'b0, cur_ff.frame, FRAC_W'(0)});
         den   = $signed({1'b0, prev_ff.frame, FRAC_W'(0)})
               - $signed({1'b0, cur_ff.frame, FRAC_W'(0)});
      end else begin
         mul_a = DIFF_W'(max_ff) - DIFF_W'(min_ff);
         mul_b = $signed({(SPAN_W - RAW_W)'(0), raw_ff});
         den   = $signed({(SPAN_W - RAW_W)'(0), RAW_FULL_SCALE});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
         den_ff  <= den;
      end
   end

   // divide: restoring, two quotient bits a cycle, quotient shifts into num
   logic [PROD_W-1:0] num_ff, num_nx, prod_mag;
   logic [DEN_W-1:0]  rem_ff, rem_nx, ud_ff, den_mag;
   logic              neg_ff;
   logic [DEN_W:0]    trial;

   assign prod_mag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign den_mag  = den_ff[SPAN_W-1] ? DEN_W'(-den_ff) : DEN_W'(den_ff);

   always_comb begin
      num_nx = num_ff;
      rem_nx = rem_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial  = {rem_nx, num_nx[PROD_W-1]};
         num_nx = {num_nx[PROD_W-2:0], 1'b0};
         if (trial >= {1'b0, ud_ff}) begin
            trial     = trial - {1'b0, ud_ff};
            num_nx[0] = 1'b1;
         end
         rem_nx = trial[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         num_ff <= prod_mag + PROD_W'(den_mag >> 1);
         rem_ff <= '0;
         ud_ff  <= den_mag;
         neg_ff <= prod_ff[PROD_W-1] ^ den_ff[SPAN_W-1];
      end else if (cmd.div_step) begin
         num_ff <= num_nx;
         rem_ff <= rem_nx;
      end
   end

   // base plus signed quotient, saturated
   logic signed [PROD_W:0]   q_signed;
   logic signed [SUM_W-1:0]  sum;
   logic signed [VAL_W-1:0]  base, sat;

   assign base     = (cmd_ff == CMD_QUERY) ? cur_ff.value : min_ff;
   assign q_signed = neg_ff ? -$signed({1'b0, num_ff}) : $signed({1'b0, num_ff});
   assign sum      = SUM_W'(base) + SUM_W'(q_signed);

   always_comb begin
      if (sum > SUM_W'(32'sh7FFF_FFFF)) begin
         sat = 32'sh7FFF_FFFF;
      end else if (sum < -SUM_W'(33'sh0_8000_0000)) begin
         sat = -32'sh8000_0000;
      end else begin
         sat = sum[VAL_W-1:0];
      end
   end

   assign result = (held_ff || flat_ff) ? cur_ff.value : sat;

   logic signed [VAL_W-1:0] out_value_ff;
   logic                    out_held_ff;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         out_value_ff <= result;
         out_held_ff  <= held_ff;
      end
   end

   assign out_value = out_value_ff;
   assign out_held  = out_held_ff;

endmodule
`default_nettype wire

### rtl/keyframe_linear_interpolator.sv
// Top level: keyframe linear interpolator for one animation channel.
`timescale 1ns / 1ps
`default_nettype none
// A load beat (cmd 0) dequantizes key_raw between min_value and max_value and
// stores frame and value in slot key_slot; it gives no response beat and runs
// through multiply, setup, 29 radix-4 divide steps and write. A query beat
// (cmd 1) walks the 256-entry key table down from key_count-1 (clamped to
// 0..255), one key a cycle through the registered read port, until a key at
// or before query_time is found or key 0 is reached; it then multiplies the
// value delta by the time offset and divides by the segment width with
// rounding to nearest. A query's length grows with the keys walked; the walk
// and the shared divider set it. At or after the last key the last value is
// held and held_last is 1, skipping the divide. The response register frees
// the datapath: a new beat is taken while a result waits. The key table has
// no reset: a slot must be loaded before a query reads it. Configuration
// (csr_index 0 min_value, 1 max_value, 2 key_count) must be written only
// while idle; the block itself does not enforce this.
module keyframe_linear_interpolator
   import kli_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   kli_req_if.sink                  req_bus,
   kli_rsp_if.source                rsp_bus,
   input  wire logic                csr_we,
   input  wire logic [CSR_AW-1:0]   csr_index,
   input  wire logic [CSR_DW-1:0]   csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   kli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   kli_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_cmd    (req_bus.cmd),
      .in_slot   (req_bus.key_slot),
      .in_frame  (req_bus.key_frame),
      .in_raw    (req_bus.key_raw),
      .in_time   (req_bus.query_time),
      .cmd       (cmd),
      .status    (status),
      .out_value (rsp_bus.sample_value),
      .out_held  (rsp_bus.held_last)
   );

endmodule
`default_nettype wire

### tb/sv/tb_keyframe_linear_interpolator.sv
// Testbench: keyframe interpolator checked beat by beat against a local channel predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_keyframe_linear_interpolator;
   import kli_pkg::*;

   // Input beat as the sender sees it
   typedef struct {
      logic        cmd;
      logic [7:0]  slot;
      logic [15:0] frame;
      logic [15:0] raw;
      logic [23:0] qtime;
   } key_beat_t;

   // Expected response beat
   typedef struct {
      logic signed [31:0] value;
      logic               held;
   } sample_t;

   // Directed rows: either a register write (done once the block is idle) or a beat
   typedef enum logic {ROW_CSR, ROW_BEAT} row_kind_t;
   typedef struct {
      row_kind_t          kind;
      logic [CSR_AW-1:0]  index;
      logic [CSR_DW-1:0]  data;
      key_beat_t          beat;
      logic               typed;   // expected value written into the row
      sample_t            want;
   } row_t;

   localparam int DRAIN_CYCLES = 48;  // covers a trailing load beat, which gives no response

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_AW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_wdata;

   kli_req_if req_bus();
   kli_rsp_if rsp_bus();

   keyframe_linear_interpolator uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state: key table and register copies
   logic [15:0]        frame_table [MAX_KEYS];
   logic signed [31:0] value_table [MAX_KEYS];
   longint             min_q;
   longint             max_q;
   int unsigned        count_q;

   sample_t expected_samples [$];
   int      mismatches;
   int      loads_sent;
   int      queries_sent;
   int      samples_seen;
   int      held_seen;
   int      sat_seen;
   int      send_idle;   // percent of cycles the sender holds back
   int      recv_idle;   // percent of cycles the receiver stalls

   // Divide rounding to nearest, ties away from zero
   function automatic longint div_nearest(longint num, longint den);
      bit     neg;
      longint un;
      longint ud;
      longint q;
      neg = (num < 0) != (den < 0);
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      q = (un + ud / 2) / ud;
      return neg ? -q : q;
   endfunction

   function automatic longint dequantize_raw(logic [15:0] raw);
      if (raw == 16'd0) return min_q;
      if (raw == RAW_FULL_SCALE) return max_q;
      return min_q + div_nearest((max_q - min_q) * longint'(raw), 64'd65535);
   endfunction

   function automatic sample_t sample_channel(logic [23:0] qt);
      sample_t     s;
      int unsigned n;
      int unsigned i;
      longint      t;
      longint      t1;
      longint      t2;
      longint      v1;
      longint      v2;
      longint      r;
      t = longint'(qt);
      n = (count_q == 0) ? 1 : ((count_q > MAX_KEYS) ? MAX_KEYS : count_q);
      i = n - 1;
      while (i > 0 && longint'(frame_table[i]) * 256 > t) i--;
      s.held = 1'b0;
      if (i == n - 1) begin
         r = value_table[i];
         s.held = 1'b1;
      end else begin
         v1 = value_table[i];
         v2 = value_table[i + 1];
         t1 = longint'(frame_table[i]) * 256;
         t2 = longint'(frame_table[i + 1]) * 256;
         if (t2 == t1) begin
            r = v1;
         end else begin
            r = v1 + div_nearest((v2 - v1) * (t - t1), t2 - t1);
            if (r > 64'sd2147483647) begin
               r = 64'sd2147483647;
               sat_seen++;
            end else if (r < -64'sd2147483648) begin
               r = -64'sd2147483648;
               sat_seen++;
            end
         end
      end
      s.value = r[31:0];
      return s;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Response side: check at the edge, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            samples_seen++;
            if (expected_samples.size() == 0) begin
               report_mismatch("response beat with nothing expected", rsp_bus.sample_value, 0);
            end else begin
               if (rsp_bus.sample_value !== expected_samples[0].value)
                  report_mismatch("sample_value", rsp_bus.sample_value,
                                  expected_samples[0].value);
               if (rsp_bus.held_last !== expected_samples[0].held)
                  report_mismatch("held_last", rsp_bus.held_last, expected_samples[0].held);
               if (expected_samples[0].held) held_seen++;
               void'(expected_samples.pop_front());
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Drive one beat; the predictor runs at acceptance. Valid stays high
   // into the next beat unless the sender chooses to idle.
   task automatic send_beat(key_beat_t b, bit typed, sample_t want);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= b.cmd;
      req_bus.key_slot   <= b.slot;
      req_bus.key_frame  <= b.frame;
      req_bus.key_raw    <= b.raw;
      req_bus.query_time <= b.qtime;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (b.cmd == CMD_LOAD) begin
         loads_sent++;
         frame_table[b.slot] = b.frame;
         value_table[b.slot] = 32'(dequantize_raw(b.raw));
      end else begin
         queries_sent++;
         expected_samples.insert(expected_samples.size(),
                                 typed ? want : sample_channel(b.qtime));
      end
   endtask

   // Wait until every response is back, then let a trailing load finish
   task automatic drain_block();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_AW-1:0] idx, logic [CSR_DW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_MIN_VALUE: min_q = longint'(signed'(data));
         CSR_MAX_VALUE: max_q = longint'(signed'(data));
         CSR_KEY_COUNT: count_q = 32'(data[CNT_W-1:0]);
         default: ;
      endcase
   endtask

   function automatic key_beat_t make_load(int slot, int frame, int raw);
      key_beat_t b;
      b.cmd   = CMD_LOAD;
      b.slot  = slot[7:0];
      b.frame = frame[15:0];
      b.raw   = raw[15:0];
      b.qtime = 24'($urandom);   // ignored on a load, but toggles the bits
      return b;
   endfunction

   function automatic key_beat_t make_query(int qt);
      key_beat_t b;
      b.cmd   = CMD_QUERY;
      b.slot  = 8'($urandom);
      b.frame = 16'($urandom);
      b.raw   = 16'($urandom);
      b.qtime = qt[23:0];
      return b;
   endfunction

   function automatic row_t beat_row(key_beat_t b, bit typed, int value, bit held);
      row_t r;
      r.kind = ROW_BEAT;
      r.index = CSR_MIN_VALUE;
      r.data = '0;
      r.beat = b;
      r.typed = typed;
      r.want.value = value;
      r.want.held = held;
      return r;
   endfunction

   function automatic row_t csr_row(logic [CSR_AW-1:0] idx, logic [31:0] data);
      row_t r;
      r = beat_row(make_load(0, 0, 0), 1'b0, 0, 1'b0);
      r.kind = ROW_CSR;
      r.index = idx;
      r.data = data;
      return r;
   endfunction

   function automatic int pick_raw();
      case ($urandom_range(7))
         0: return 0;
         1: return 65535;
         default: return $urandom_range(65535);
      endcase
   endfunction

   // Query time near the keys, on a key, or anywhere
   function automatic int pick_time(int unsigned n);
      int unsigned j;
      int          t;
      j = $urandom_range(n - 1);
      case ($urandom_range(5))
         0: return $urandom_range(24'hFFFFFF);
         1: return {frame_table[j], 8'h00};
         2: return 24'hFFFFFF;
         default: begin
            t = {frame_table[j], 8'h00} + $urandom_range(0, 4095) - 1024;
            if (t < 0) t = $urandom_range(255);
            if (t > 24'hFFFFFF) t = 24'hFFFFFF;
            return t;
         end
      endcase
   endfunction

   // Frame for a slot that mostly keeps the table ascending where the neighbors allow
   function automatic int pick_frame(int unsigned slot, int unsigned n);
      int lo;
      int hi;
      if ($urandom_range(7) == 0) return $urandom_range(65535);
      lo = (slot == 0) ? 0 : frame_table[slot - 1];
      hi = (slot + 1 >= n) ? lo + 64 : frame_table[slot + 1];
      if (hi > 65535) hi = 65535;
      if (hi < lo) return lo;
      return $urandom_range(hi, lo);
   endfunction

   row_t directed [$];
   int   count_plan [12] = '{2, 8, 1, 40, 3, 0, 511, 16, 2, 5, 9, 256};

   function automatic void add_row(row_t r);
      directed.insert(directed.size(), r);
   endfunction

   initial begin
      automatic sample_t     none;
      automatic int unsigned n;
      automatic int unsigned slot;
      automatic int          frame;
      automatic int          items;
      automatic int          waited;
      none.value = 0;
      none.held  = 1'b0;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_MIN_VALUE;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= CMD_LOAD;
      req_bus.key_slot  <= '0;
      req_bus.key_frame <= '0;
      req_bus.key_raw   <= '0;
      req_bus.query_time <= '0;
      mismatches = 0;
      loads_sent = 0;
      queries_sent = 0;
      samples_seen = 0;
      held_seen = 0;
      sat_seen = 0;
      send_idle = 26;
      recv_idle = 48;
      min_q = 0;
      max_q = 65536;
      count_q = 1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: defaults after reset, then full-scale range,
      // saturation at the low end, the zero-width first segment, key counts of
      // zero and one, and the top frame number.
      add_row(beat_row(make_load(0, 0, 0), 1'b0, 0, 1'b0));
      add_row(beat_row(make_query(0), 1'b1, 0, 1'b1));
      add_row(beat_row(make_load(0, 10, 65535), 1'b0, 0, 1'b0));
      add_row(beat_row(make_query(24'hFFFFFF), 1'b1, 65536, 1'b1));
      add_row(csr_row(CSR_MIN_VALUE, 32'h8000_0000));
      add_row(csr_row(CSR_MAX_VALUE, 32'h7FFF_FFFF));
      add_row(csr_row(CSR_KEY_COUNT, 32'd2));
      add_row(beat_row(make_load(0, 100, 0), 1'b0, 0, 1'b0));
      add_row(beat_row(make_load(1, 200, 65535), 1'b0, 0, 1'b0));
      add_row(beat_row(make_query(150 * 256), 1'b0, 0, 1'b0));
      add_row(beat_row(make_query(0), 1'b1, 32'h8000_0000, 1'b0));
      add_row(beat_row(make_query(200 * 256), 1'b1, 32'h7FFF_FFFF, 1'b1));
      add_row(beat_row(make_query(100 * 256 + 77), 1'b0, 0, 1'b0));
      add_row(beat_row(make_load(1, 100, 12345), 1'b0, 0, 1'b0));
      add_row(beat_row(make_query(50 * 256), 1'b1, 32'h8000_0000, 1'b0));
      add_row(csr_row(CSR_MIN_VALUE, 32'h7FFF_FFFF));
      add_row(csr_row(CSR_MAX_VALUE, 32'h8000_0000));
      add_row(beat_row(make_load(0, 0, 65535), 1'b0, 0, 1'b0));
      add_row(beat_row(make_load(1, 65535, 1), 1'b0, 0, 1'b0));
      add_row(beat_row(make_query(300), 1'b0, 0, 1'b0));
      add_row(csr_row(CSR_KEY_COUNT, 32'd0));
      add_row(beat_row(make_query(12345), 1'b1, 32'h8000_0000, 1'b1));
      add_row(csr_row(CSR_KEY_COUNT, 32'd2));
      add_row(beat_row(make_query(24'hFFFFFF), 1'b0, 0, 1'b0));
      foreach (directed[k]) begin
         if (directed[k].kind == ROW_CSR) begin
            drain_block();
            write_csr(directed[k].index, directed[k].data);
         end else begin
            send_beat(directed[k].beat, directed[k].typed, directed[k].want);
         end
      end

      // Random part: three idling regimes, four register settings each
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 26 : ((ph == 1) ? 48 : 0);
         recv_idle = (ph == 0) ? 48 : ((ph == 1) ? 26 : 0);
         for (int k = 0; k < 4; k++) begin
            drain_block();
            case (k)
               0: begin
                  write_csr(CSR_MIN_VALUE, 32'h8000_0000);
                  write_csr(CSR_MAX_VALUE, 32'h7FFF_FFFF);
               end
               1: begin
                  write_csr(CSR_MIN_VALUE, 32'h7FFF_FFFF);
                  write_csr(CSR_MAX_VALUE, 32'h8000_0000);
               end
               default: begin
                  write_csr(CSR_MIN_VALUE, $urandom);
                  write_csr(CSR_MAX_VALUE, $urandom_range(1, 0) ? $urandom
                                           : csr_wdata + $urandom_range(1 << 20));
               end
            endcase
            write_csr(CSR_KEY_COUNT, count_plan[ph * 4 + k]);
            n = (count_q == 0) ? 1 : ((count_q > MAX_KEYS) ? MAX_KEYS : count_q);

            // Fill every slot a query can read, ascending with some repeats
            frame = (n > 200) ? $urandom_range(300) : $urandom_range(60000);
            for (int unsigned s = 0; s < n; s++) begin
               send_beat(make_load(s, frame, pick_raw()), 1'b0, none);
               if ($urandom_range(15) != 0) frame += $urandom_range(1, 40);
               if (frame > 65535) frame = 65535;
            end

            // Mostly queries, with overwrites that mostly keep the order
            items = (n > 200) ? 50 : 150;
            for (int m = 0; m < items; m++) begin
               if ($urandom_range(99) < 78) begin
                  send_beat(make_query(pick_time(n)), 1'b0, none);
               end else if ($urandom_range(9) == 0) begin
                  send_beat(make_load($urandom_range(255), $urandom_range(65535),
                                      pick_raw()), 1'b0, none);
               end else begin
                  slot = $urandom_range(n - 1);
                  send_beat(make_load(slot, pick_frame(slot, n), pick_raw()), 1'b0, none);
               end
            end
         end
      end

      // Final drain with its own bound
      req_bus.valid <= 1'b0;
      waited = 0;
      while (expected_samples.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_samples.size() != 0) begin
         report_mismatch("response beats never arrived", expected_samples.size(), 0);
      end
      $display("Covered %0d load beats and %0d query beats, %0d responses checked",
               loads_sent, queries_sent, samples_seen);
      $display("  %0d held at the last key, %0d saturated", held_seen, sat_seen);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #100ms;
      $display("Timed out");
      $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire
